// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks shared by the RTL. They expect clk and arst_n in
// the scope of the module that uses them.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/vwf_pkg.sv -----
// ---------------------------------------------------------------------------
// vwf_pkg
// Widths, constants, register indexes and unit request/response types of the
// velocity window feature extractor.
// ---------------------------------------------------------------------------
`default_nettype none

package vwf_pkg;

	// Window and stride
	localparam int WIN_LEN    = 64;
	localparam int WIN_AW     = $clog2(WIN_LEN);
	localparam int FILL_W     = $clog2(WIN_LEN + 1);
	localparam int STRIDE_LEN = 16;
	localparam int STRIDE_W   = $clog2(STRIDE_LEN + 1);

	// Samples
	localparam int VEL_W  = 16;
	localparam int SAMP_W = 14;
	localparam logic [SAMP_W-1:0] VEL_MAX = 14'd10240;
	localparam int SQR_W  = $clog2(int'(VEL_MAX) * int'(VEL_MAX) + 1);

	// Running sums and variance
	localparam int SUM_W  = SAMP_W + WIN_AW;
	localparam int SQ_W   = SQR_W + WIN_AW;
	localparam int NUM_W  = SQ_W + WIN_AW;
	localparam int VAR_W  = NUM_W - 2 * WIN_AW;
	localparam int ROOT_W = (VAR_W + 1) / 2;
	localparam int RAD_W  = 2 * ROOT_W;

	// Zero ratio in Q1.8
	localparam int RATIO_FRAC = 8;
	localparam int RATIO_W    = $clog2((1 << RATIO_FRAC) + 1);

	// Configuration
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int GAIN_W     = 24;
	localparam int OFS_W      = 16;
	localparam logic signed [GAIN_W-1:0] GAIN_RESET = 24'sd65536;

	localparam logic [CFG_IDX_W-1:0] CFG_MEAN_GAIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STD_GAIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAN_OFFSET  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STD_OFFSET   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_OFFSET  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO_OFFSET = 3'd7;

	// Features
	localparam int FEAT_N     = 4;
	localparam int FEAT_IDX_W = 2;
	localparam int FEAT_W     = 8;
	localparam int FEAT_MIN   = -128;
	localparam int FEAT_MAX   = 127;
	localparam logic [FEAT_IDX_W-1:0] FEAT_MEAN  = 2'd0;
	localparam logic [FEAT_IDX_W-1:0] FEAT_STD   = 2'd1;
	localparam logic [FEAT_IDX_W-1:0] FEAT_LAST  = 2'd2;
	localparam logic [FEAT_IDX_W-1:0] FEAT_RATIO = 2'd3;

	// Serial multiplier: one digit of b per cycle
	localparam int DIGIT_W   = 4;
	localparam int MUL_A_W   = GAIN_W;
	localparam int MUL_STEPS = (SUM_W + DIGIT_W - 1) / DIGIT_W;
	localparam int MUL_B_W   = MUL_STEPS * DIGIT_W;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int PROD_FRAC = 24;

	typedef struct packed {
		logic               start;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic [MUL_P_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic             start;
		logic [RAD_W-1:0] radicand;
	} sqrt_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} sqrt_rsp_t;

endpackage

`default_nettype wire

// ----- src/vwf_if.sv -----
// ---------------------------------------------------------------------------
// vwf stream interfaces
// Valid/ready channels for velocity samples in and feature items out.
// ---------------------------------------------------------------------------
`default_nettype none

interface vwf_vel_if;
	logic                                valid;
	logic                                ready;
	logic signed [vwf_pkg::VEL_W-1:0]    velocity_in;

	modport source (output valid, output velocity_in, input ready);
	modport sink (input valid, input velocity_in, output ready);
endinterface

interface vwf_feat_if;
	logic                                valid;
	logic                                ready;
	logic signed [vwf_pkg::FEAT_W-1:0]   mean_feature;
	logic signed [vwf_pkg::FEAT_W-1:0]   std_feature;
	logic signed [vwf_pkg::FEAT_W-1:0]   last_feature;
	logic signed [vwf_pkg::FEAT_W-1:0]   ratio_feature;

	modport source (output valid, output mean_feature, output std_feature,
		output last_feature, output ratio_feature, input ready);
	modport sink (input valid, input mean_feature, input std_feature,
		input last_feature, input ratio_feature, output ready);
endinterface

`default_nettype wire

// ----- src/vwf_serial_mul.sv -----
// ---------------------------------------------------------------------------
// vwf_serial_mul
// Unsigned digit-serial multiplier: b is shifted out one digit per cycle,
// most significant first, and accumulated against a.
// ---------------------------------------------------------------------------
`default_nettype none

module vwf_serial_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  vwf_pkg::mul_req_t req,
	output vwf_pkg::mul_rsp_t rsp
);

	localparam int CNT_W = $clog2(vwf_pkg::MUL_STEPS + 1);

	logic [vwf_pkg::MUL_A_W-1:0]                  a_q;
	logic [vwf_pkg::MUL_B_W-1:0]                  b_q;
	logic [vwf_pkg::MUL_P_W-1:0]                  acc_q;
	logic [CNT_W-1:0]                             cnt_q;
	logic                                         done_q;
	logic [vwf_pkg::DIGIT_W-1:0]                  digit;
	logic [vwf_pkg::MUL_A_W+vwf_pkg::DIGIT_W-1:0] part;

	// Partial product of the current top digit
	assign digit = b_q[vwf_pkg::MUL_B_W-1 -: vwf_pkg::DIGIT_W];
	assign part  = a_q * digit;

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CNT_W'(vwf_pkg::MUL_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	// Shift the multiplier and accumulate
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			b_q   <= {b_q[vwf_pkg::MUL_B_W-vwf_pkg::DIGIT_W-1:0], {vwf_pkg::DIGIT_W{1'b0}}};
			acc_q <= {acc_q[vwf_pkg::MUL_P_W-vwf_pkg::DIGIT_W-1:0], {vwf_pkg::DIGIT_W{1'b0}}}
				+ vwf_pkg::MUL_P_W'(part);
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

`default_nettype wire

// ----- src/vwf_isqrt.sv -----
// ---------------------------------------------------------------------------
// vwf_isqrt
// Restoring integer square root: two radicand bits enter per cycle and one
// root bit leaves, giving the floor of the root.
// ---------------------------------------------------------------------------
`default_nettype none

module vwf_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  vwf_pkg::sqrt_req_t req,
	output vwf_pkg::sqrt_rsp_t rsp
);

	localparam int REM_W = vwf_pkg::ROOT_W + 3;
	localparam int CNT_W = $clog2(vwf_pkg::ROOT_W + 1);

	logic [vwf_pkg::RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]           rem_q;
	logic [vwf_pkg::ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       done_q;
	logic [REM_W-1:0]           rem_sh;
	logic [REM_W-1:0]           trial;
	logic                       fits;

	// Bring down the next bit pair and try the next root bit
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[vwf_pkg::RAD_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign fits   = (rem_sh >= trial);

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CNT_W'(vwf_pkg::ROOT_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	// Shift the radicand, update remainder and root
	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[vwf_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[vwf_pkg::ROOT_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

`default_nettype wire

// ----- src/velocity_window_feature_extractor_unit.sv -----
// ---------------------------------------------------------------------------
// velocity_window_feature_extractor_unit
// An item without a result runs two squares on the 4-bit digit-serial
// multiplier, of the new sample and of the one leaving the window; an item
// with a result also runs the sum square, the 14-step serial root and four
// gain products before its features are shown.
// Reset clears the window, counters and sums and loads gains of 1.0, offsets 0.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module velocity_window_feature_extractor_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	vwf_vel_if.sink                          samples,
	vwf_feat_if.source                       features,
	input  logic                             cfg_we,
	input  logic [vwf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vwf_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
	localparam logic [ST_W-1:0] S_SQN    = 4'd1;
	localparam logic [ST_W-1:0] S_SQO    = 4'd2;
	localparam logic [ST_W-1:0] S_UPD    = 4'd3;
	localparam logic [ST_W-1:0] S_SQS_GO = 4'd4;
	localparam logic [ST_W-1:0] S_SQS    = 4'd5;
	localparam logic [ST_W-1:0] S_VAR    = 4'd6;
	localparam logic [ST_W-1:0] S_ROOT   = 4'd7;
	localparam logic [ST_W-1:0] S_Q_GO   = 4'd8;
	localparam logic [ST_W-1:0] S_Q      = 4'd9;
	localparam logic [ST_W-1:0] S_OUT    = 4'd10;

	localparam int Q_INT_W = vwf_pkg::MUL_P_W - vwf_pkg::PROD_FRAC;
	localparam int R_W     = Q_INT_W + 3;
	localparam logic [vwf_pkg::PROD_FRAC-1:0] ROUND_HALF =
		{1'b1, {(vwf_pkg::PROD_FRAC-1){1'b0}}};

	// Round to nearest even, apply sign and offset, saturate to int8
	function automatic logic signed [vwf_pkg::FEAT_W-1:0] quantize(
		input logic [vwf_pkg::MUL_P_W-1:0]     prod,
		input logic                            neg,
		input logic signed [vwf_pkg::OFS_W-1:0] ofs
	);
		logic [Q_INT_W-1:0]             q;
		logic [vwf_pkg::PROD_FRAC-1:0]  rem;
		logic                           up;
		logic [Q_INT_W:0]               qr;
		logic signed [R_W-1:0]          mag;
		logic signed [R_W-1:0]          r;
		logic signed [vwf_pkg::FEAT_W-1:0] res;
		q   = prod[vwf_pkg::MUL_P_W-1:vwf_pkg::PROD_FRAC];
		rem = prod[vwf_pkg::PROD_FRAC-1:0];
		up  = (rem > ROUND_HALF) || ((rem == ROUND_HALF) && q[0]);
		qr  = {1'b0, q} + (Q_INT_W+1)'(up);
		mag = $signed({2'b00, qr});
		r   = neg ? -mag : mag;
		r   = r + R_W'(ofs);
		if (r < vwf_pkg::FEAT_MIN) begin
			res = vwf_pkg::FEAT_W'(vwf_pkg::FEAT_MIN);
		end else if (r > vwf_pkg::FEAT_MAX) begin
			res = vwf_pkg::FEAT_W'(vwf_pkg::FEAT_MAX);
		end else begin
			res = r[vwf_pkg::FEAT_W-1:0];
		end
		return res;
	endfunction

	logic [ST_W-1:0]                         state_q;
	logic [ST_W-1:0]                         state_d;
	logic signed [vwf_pkg::GAIN_W-1:0]       gain_q [vwf_pkg::FEAT_N];
	logic signed [vwf_pkg::OFS_W-1:0]        ofs_q [vwf_pkg::FEAT_N];
	logic [vwf_pkg::SAMP_W-1:0]              ring_mem [vwf_pkg::WIN_LEN];
	logic [vwf_pkg::SAMP_W-1:0]              ring_rd_q;
	logic [vwf_pkg::SAMP_W-1:0]              v_q;
	logic [vwf_pkg::SAMP_W-1:0]              v_clip;
	logic [vwf_pkg::SAMP_W-1:0]              old_eff;
	logic [vwf_pkg::WIN_AW-1:0]              wpos_q;
	logic [vwf_pkg::FILL_W-1:0]              fill_q;
	logic [vwf_pkg::FILL_W-1:0]              fill_next;
	logic [vwf_pkg::STRIDE_W-1:0]            stride_q;
	logic [vwf_pkg::STRIDE_W-1:0]            stride_next;
	logic [vwf_pkg::SUM_W-1:0]               sum_q;
	logic [vwf_pkg::SQ_W-1:0]                sq_q;
	logic [vwf_pkg::SQ_W-1:0]                newsq_q;
	logic [vwf_pkg::FILL_W-1:0]              zero_q;
	logic [vwf_pkg::ROOT_W-1:0]              std_q;
	logic [vwf_pkg::FEAT_IDX_W-1:0]          k_q;
	logic signed [vwf_pkg::FEAT_W-1:0]       res_q [vwf_pkg::FEAT_N];
	logic signed [vwf_pkg::FEAT_W-1:0]       out_q [vwf_pkg::FEAT_N];
	logic                                    out_valid_q;
	logic                                    accept;
	logic                                    full;
	logic                                    emit;
	logic                                    zero_inc;
	logic                                    zero_dec;
	logic                                    out_load;
	logic signed [vwf_pkg::GAIN_W-1:0]       gain_sel;
	logic [vwf_pkg::MUL_A_W-1:0]             gain_mag;
	logic [vwf_pkg::MUL_B_W-1:0]             feat_sel;
	logic [vwf_pkg::RATIO_W-1:0]             ratio;
	logic [vwf_pkg::NUM_W-1:0]               num;
	logic [vwf_pkg::NUM_W-1:0]               sumsq;
	logic [vwf_pkg::NUM_W-1:0]               diff;
	logic [vwf_pkg::VAR_W-1:0]               var_val;
	vwf_pkg::mul_req_t                       mul_req;
	vwf_pkg::mul_rsp_t                       mul_rsp;
	vwf_pkg::sqrt_req_t                      sqrt_req;
	vwf_pkg::sqrt_rsp_t                      sqrt_rsp;

	// Shared serial multiplier and square root unit
	vwf_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	vwf_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.rsp    (sqrt_rsp)
	);

	// Handshakes
	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign out_load      = (state_q == S_OUT) && (!out_valid_q || features.ready);

	// Clip the incoming sample to 0..40.0
	always_comb begin
		if (samples.velocity_in[vwf_pkg::VEL_W-1]) begin
			v_clip = '0;
		end else if (samples.velocity_in[vwf_pkg::VEL_W-2:0] >
				(vwf_pkg::VEL_W-1)'(vwf_pkg::VEL_MAX)) begin
			v_clip = vwf_pkg::VEL_MAX;
		end else begin
			v_clip = samples.velocity_in[vwf_pkg::SAMP_W-1:0];
		end
	end

	// Window bookkeeping
	assign full        = (fill_q == vwf_pkg::FILL_W'(vwf_pkg::WIN_LEN));
	assign old_eff     = full ? ring_rd_q : '0;
	assign fill_next   = full ? fill_q : fill_q + 1'b1;
	assign stride_next = (stride_q == vwf_pkg::STRIDE_W'(vwf_pkg::STRIDE_LEN)) ?
		stride_q : stride_q + 1'b1;
	assign emit        = (fill_next == vwf_pkg::FILL_W'(vwf_pkg::WIN_LEN)) &&
		(stride_next == vwf_pkg::STRIDE_W'(vwf_pkg::STRIDE_LEN));
	assign zero_inc    = (v_q == '0);
	assign zero_dec    = full && (old_eff == '0) && (zero_q != '0);

	// Variance from the sum square held in the multiplier
	assign num     = {sq_q, {vwf_pkg::WIN_AW{1'b0}}};
	assign sumsq   = mul_rsp.prod[vwf_pkg::NUM_W-1:0];
	assign diff    = num - sumsq;
	assign var_val = (num > sumsq) ? diff[vwf_pkg::NUM_W-1:2*vwf_pkg::WIN_AW] : '0;

	assign sqrt_req.start    = (state_q == S_VAR);
	assign sqrt_req.radicand = vwf_pkg::RAD_W'(var_val);

	// Zero ratio in Q1.8
	assign ratio = vwf_pkg::RATIO_W'({zero_q, {vwf_pkg::RATIO_FRAC{1'b0}}} >> vwf_pkg::WIN_AW);

	// Gain magnitude for the current feature
	assign gain_sel = gain_q[k_q];
	assign gain_mag = gain_sel[vwf_pkg::GAIN_W-1] ? vwf_pkg::MUL_A_W'(-gain_sel) :
		vwf_pkg::MUL_A_W'(gain_sel);

	// Select the feature to scale
	always_comb begin
		case (k_q)
			vwf_pkg::FEAT_MEAN:  feat_sel = vwf_pkg::MUL_B_W'(sum_q[vwf_pkg::SUM_W-1:vwf_pkg::WIN_AW]);
			vwf_pkg::FEAT_STD:   feat_sel = vwf_pkg::MUL_B_W'(std_q);
			vwf_pkg::FEAT_LAST:  feat_sel = vwf_pkg::MUL_B_W'(v_q);
			default:             feat_sel = vwf_pkg::MUL_B_W'(ratio);
		endcase
	end

	// Drive the multiplier operands
	always_comb begin
		mul_req.start = 1'b0;
		mul_req.a     = '0;
		mul_req.b     = '0;
		unique case (state_q)
			S_IDLE: begin
				mul_req.start = accept;
				mul_req.a     = vwf_pkg::MUL_A_W'(v_clip);
				mul_req.b     = vwf_pkg::MUL_B_W'(v_clip);
			end
			S_SQN: begin
				mul_req.start = mul_rsp.done;
				mul_req.a     = vwf_pkg::MUL_A_W'(old_eff);
				mul_req.b     = vwf_pkg::MUL_B_W'(old_eff);
			end
			S_SQS_GO: begin
				mul_req.start = 1'b1;
				mul_req.a     = vwf_pkg::MUL_A_W'(sum_q);
				mul_req.b     = vwf_pkg::MUL_B_W'(sum_q);
			end
			S_Q_GO: begin
				mul_req.start = 1'b1;
				mul_req.a     = gain_mag;
				mul_req.b     = feat_sel;
			end
			default: begin
				mul_req.start = 1'b0;
			end
		endcase
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (accept) state_d = S_SQN;
			S_SQN:    if (mul_rsp.done) state_d = S_SQO;
			S_SQO:    if (mul_rsp.done) state_d = S_UPD;
			S_UPD:    state_d = emit ? S_SQS_GO : S_IDLE;
			S_SQS_GO: state_d = S_SQS;
			S_SQS:    if (mul_rsp.done) state_d = S_VAR;
			S_VAR:    state_d = S_ROOT;
			S_ROOT:   if (sqrt_rsp.done) state_d = S_Q_GO;
			S_Q_GO:   state_d = S_Q;
			S_Q: begin
				if (mul_rsp.done) begin
					state_d = (k_q == vwf_pkg::FEAT_RATIO) ? S_OUT : S_Q_GO;
				end
			end
			S_OUT:    if (out_load) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Control state, window counters and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wpos_q      <= '0;
			fill_q      <= '0;
			stride_q    <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			zero_q      <= '0;
			k_q         <= vwf_pkg::FEAT_MEAN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_UPD) begin
				sum_q    <= sum_q - vwf_pkg::SUM_W'(old_eff) + vwf_pkg::SUM_W'(v_q);
				sq_q     <= sq_q - mul_rsp.prod[vwf_pkg::SQ_W-1:0] + newsq_q;
				zero_q   <= zero_q + vwf_pkg::FILL_W'(zero_inc) - vwf_pkg::FILL_W'(zero_dec);
				fill_q   <= fill_next;
				stride_q <= emit ? '0 : stride_next;
				wpos_q   <= (wpos_q == vwf_pkg::WIN_AW'(vwf_pkg::WIN_LEN - 1)) ?
					'0 : wpos_q + 1'b1;
				k_q      <= vwf_pkg::FEAT_MEAN;
			end
			if ((state_q == S_Q) && mul_rsp.done) begin
				k_q <= k_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (features.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < vwf_pkg::FEAT_N; i++) begin
				gain_q[i] <= vwf_pkg::GAIN_RESET;
				ofs_q[i]  <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				vwf_pkg::CFG_MEAN_GAIN, vwf_pkg::CFG_STD_GAIN,
				vwf_pkg::CFG_LAST_GAIN, vwf_pkg::CFG_RATIO_GAIN: begin
					gain_q[cfg_index[vwf_pkg::FEAT_IDX_W-1:0]] <= cfg_data;
				end
				vwf_pkg::CFG_MEAN_OFFSET, vwf_pkg::CFG_STD_OFFSET,
				vwf_pkg::CFG_LAST_OFFSET, vwf_pkg::CFG_RATIO_OFFSET: begin
					ofs_q[cfg_index[vwf_pkg::FEAT_IDX_W-1:0]] <= cfg_data[vwf_pkg::OFS_W-1:0];
				end
			endcase
		end
	end

	// Sample ring: read the oldest entry on accept, overwrite it on update
	always_ff @(posedge clk) begin
		if (state_q == S_UPD) begin
			ring_mem[wpos_q] <= v_q;
		end
		if (accept) begin
			ring_rd_q <= ring_mem[wpos_q];
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q <= v_clip;
		end
		if ((state_q == S_SQN) && mul_rsp.done) begin
			newsq_q <= mul_rsp.prod[vwf_pkg::SQ_W-1:0];
		end
		if ((state_q == S_ROOT) && sqrt_rsp.done) begin
			std_q <= sqrt_rsp.root;
		end
		if ((state_q == S_Q) && mul_rsp.done) begin
			res_q[k_q] <= quantize(mul_rsp.prod, gain_sel[vwf_pkg::GAIN_W-1], ofs_q[k_q]);
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign features.valid         = out_valid_q;
	assign features.mean_feature  = out_q[vwf_pkg::FEAT_MEAN];
	assign features.std_feature   = out_q[vwf_pkg::FEAT_STD];
	assign features.last_feature  = out_q[vwf_pkg::FEAT_LAST];
	assign features.ratio_feature = out_q[vwf_pkg::FEAT_RATIO];

	// Checks
	`ASSERT_NEXT(a_accept_starts, samples.valid && samples.ready, state_q == S_SQN, "accepted item did not start squaring")
	`ASSERT_IMPLIES(a_mul_done_waited, mul_rsp.done, (state_q == S_SQN) || (state_q == S_SQO) || (state_q == S_SQS) || (state_q == S_Q), "multiplier finished with nobody waiting")
	`ASSERT_IMPLIES(a_sqrt_done_waited, sqrt_rsp.done, state_q == S_ROOT, "square root finished outside the root wait")
	`ASSERT_ALWAYS(a_zero_tally, zero_q <= fill_q, "zero tally exceeds window fill")
	`ASSERT_IMPLIES(a_out_from_seq, $rose(out_valid_q), $past(state_q) == S_OUT, "result raised outside the output step")

endmodule

`default_nettype wire

// ----- tb/velocity_window_feature_extractor_unit_tb.sv -----
// ---------------------------------------------------------------------------
// velocity_window_feature_extractor_unit_tb
// Streams speed samples into the unit and keeps its own model of the sliding
// window: clipping, running sums, zero tally and the stride count. Expected
// int8 features are queued when a sample ends a stride on a full window and
// compared with each item that leaves the unit. The run steps through
// several gain and offset settings, including the extremes, with random
// gaps on both channels and one long output hold that backs the unit up.
// ---------------------------------------------------------------------------
`default_nettype none

typedef struct packed {
	logic signed [vwf_pkg::FEAT_W-1:0] mean;
	logic signed [vwf_pkg::FEAT_W-1:0] sdev;
	logic signed [vwf_pkg::FEAT_W-1:0] last;
	logic signed [vwf_pkg::FEAT_W-1:0] ratio;
} feature_set_t;

typedef enum int {SEG_ANY, SEG_RANGE, SEG_ZEROS, SEG_FLAT, SEG_EDGES, SEG_LOW} seg_kind_t;

class feature_scoreboard;
	logic signed [vwf_pkg::GAIN_W-1:0] gain [vwf_pkg::FEAT_N];
	logic signed [vwf_pkg::OFS_W-1:0]  offset [vwf_pkg::FEAT_N];
	logic [vwf_pkg::SAMP_W-1:0]        ring [vwf_pkg::WIN_LEN];
	logic [vwf_pkg::WIN_AW-1:0]        write_pos;
	int unsigned                       fill_count;
	int unsigned                       stride_count;
	int unsigned                       zero_tally;
	longint unsigned                   win_sum;
	longint unsigned                   win_sq_sum;
	feature_set_t                      expected_features [$];
	int unsigned                       samples;
	int unsigned                       results;
	int unsigned                       mismatches;
	int unsigned                       clipped_low;
	int unsigned                       clipped_high;

	function new();
		int i;
		for (i = 0; i < vwf_pkg::FEAT_N; i++) begin
			gain[i]   = vwf_pkg::GAIN_RESET;
			offset[i] = '0;
		end
		for (i = 0; i < vwf_pkg::WIN_LEN; i++)
			ring[i] = '0;
		write_pos    = '0;
		fill_count   = 0;
		stride_count = 0;
		zero_tally   = 0;
		win_sum      = 0;
		win_sq_sum   = 0;
		samples      = 0;
		results      = 0;
		mismatches   = 0;
		clipped_low  = 0;
		clipped_high = 0;
	endfunction

	// Mirror one register write
	function void set_reg(logic [vwf_pkg::CFG_IDX_W-1:0] idx,
		logic [vwf_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			vwf_pkg::CFG_MEAN_GAIN:    gain[vwf_pkg::FEAT_MEAN]    = data[vwf_pkg::GAIN_W-1:0];
			vwf_pkg::CFG_STD_GAIN:     gain[vwf_pkg::FEAT_STD]     = data[vwf_pkg::GAIN_W-1:0];
			vwf_pkg::CFG_LAST_GAIN:    gain[vwf_pkg::FEAT_LAST]    = data[vwf_pkg::GAIN_W-1:0];
			vwf_pkg::CFG_RATIO_GAIN:   gain[vwf_pkg::FEAT_RATIO]   = data[vwf_pkg::GAIN_W-1:0];
			vwf_pkg::CFG_MEAN_OFFSET:  offset[vwf_pkg::FEAT_MEAN]  = data[vwf_pkg::OFS_W-1:0];
			vwf_pkg::CFG_STD_OFFSET:   offset[vwf_pkg::FEAT_STD]   = data[vwf_pkg::OFS_W-1:0];
			vwf_pkg::CFG_LAST_OFFSET:  offset[vwf_pkg::FEAT_LAST]  = data[vwf_pkg::OFS_W-1:0];
			vwf_pkg::CFG_RATIO_OFFSET: offset[vwf_pkg::FEAT_RATIO] = data[vwf_pkg::OFS_W-1:0];
			default: ;
		endcase
	endfunction

	// Scale by a Q8.16 gain, round half to even on the magnitude, add offset, saturate
	function logic signed [vwf_pkg::FEAT_W-1:0] quantise(logic signed [vwf_pkg::GAIN_W-1:0] g,
		longint unsigned feat, logic signed [vwf_pkg::OFS_W-1:0] ofs);
		longint          gs;
		longint          r;
		longint unsigned mag;
		longint unsigned prod;
		longint unsigned q;
		longint unsigned rem;
		longint unsigned half;
		gs   = g;
		mag  = (gs < 0) ? -gs : gs;
		prod = mag * feat;
		q    = prod >> vwf_pkg::PROD_FRAC;
		rem  = prod & ((64'd1 << vwf_pkg::PROD_FRAC) - 1);
		half = 64'd1 << (vwf_pkg::PROD_FRAC - 1);
		if (rem > half || (rem == half && q[0]))
			q++;
		r = (gs < 0) ? -longint'(q) : longint'(q);
		r = r + ofs;
		if (r < vwf_pkg::FEAT_MIN)
			r = vwf_pkg::FEAT_MIN;
		if (r > vwf_pkg::FEAT_MAX)
			r = vwf_pkg::FEAT_MAX;
		return r[vwf_pkg::FEAT_W-1:0];
	endfunction

	// Push one accepted sample through the window and queue any features it gives
	function void note_sample(logic signed [vwf_pkg::VEL_W-1:0] raw);
		logic [vwf_pkg::SAMP_W-1:0] v;
		logic [vwf_pkg::SAMP_W-1:0] old;
		longint unsigned            mean;
		longint unsigned            num;
		longint unsigned            sqs;
		longint unsigned            variance;
		longint unsigned            sdev;
		longint unsigned            ratio;
		longint unsigned            probe;
		longint unsigned            rest;
		feature_set_t               f;
		samples++;
		// Clip to 0 .. 40.0
		if (raw < 0) begin
			v = '0;
			clipped_low++;
		end else if (int'(raw) > int'(vwf_pkg::VEL_MAX)) begin
			v = vwf_pkg::VEL_MAX;
			clipped_high++;
		end else begin
			v = raw[vwf_pkg::SAMP_W-1:0];
		end

		// Evict the oldest entry once the window is full
		if (fill_count >= vwf_pkg::WIN_LEN) begin
			old        = ring[write_pos];
			win_sum    = win_sum - old;
			win_sq_sum = win_sq_sum - longint'(old) * longint'(old);
			if (old == 0 && zero_tally > 0)
				zero_tally--;
		end
		ring[write_pos] = v;
		win_sum         = win_sum + v;
		win_sq_sum      = win_sq_sum + longint'(v) * longint'(v);
		if (v == 0)
			zero_tally++;
		write_pos++;
		if (fill_count < vwf_pkg::WIN_LEN)
			fill_count++;
		if (stride_count < vwf_pkg::STRIDE_LEN)
			stride_count++;

		if (fill_count < vwf_pkg::WIN_LEN || stride_count < vwf_pkg::STRIDE_LEN)
			return;
		stride_count = 0;

		mean     = win_sum / vwf_pkg::WIN_LEN;
		num      = win_sq_sum * vwf_pkg::WIN_LEN;
		sqs      = win_sum * win_sum;
		variance = (num > sqs) ? (num - sqs) / (vwf_pkg::WIN_LEN * vwf_pkg::WIN_LEN) : 0;

		// Integer square root, two bits per step
		sdev  = 0;
		rest  = variance;
		probe = 64'd1 << 62;
		while (probe > rest)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rest >= sdev + probe) begin
				rest = rest - (sdev + probe);
				sdev = (sdev >> 1) + probe;
			end else begin
				sdev = sdev >> 1;
			end
			probe = probe >> 2;
		end

		ratio = (longint'(zero_tally) << vwf_pkg::RATIO_FRAC) / vwf_pkg::WIN_LEN;

		f.mean  = quantise(gain[vwf_pkg::FEAT_MEAN], mean, offset[vwf_pkg::FEAT_MEAN]);
		f.sdev  = quantise(gain[vwf_pkg::FEAT_STD], sdev, offset[vwf_pkg::FEAT_STD]);
		f.last  = quantise(gain[vwf_pkg::FEAT_LAST], v, offset[vwf_pkg::FEAT_LAST]);
		f.ratio = quantise(gain[vwf_pkg::FEAT_RATIO], ratio, offset[vwf_pkg::FEAT_RATIO]);
		expected_features.push_back(f);
	endfunction

	task report_mismatch(string what, integer want, integer got);
		if (mismatches < 40)
			$display("feature item %0d: %s expected %0d got %0d", results, what, want, got);
		mismatches++;
	endtask

	// Compare one output item with the oldest expectation
	task check_features(feature_set_t got);
		feature_set_t want;
		results++;
		if (expected_features.size() == 0) begin
			report_mismatch("item with nothing expected, mean_feature", 0, got.mean);
			return;
		end
		want = expected_features.pop_front();
		if (got.mean !== want.mean)
			report_mismatch("mean_feature", want.mean, got.mean);
		if (got.sdev !== want.sdev)
			report_mismatch("std_feature", want.sdev, got.sdev);
		if (got.last !== want.last)
			report_mismatch("last_feature", want.last, got.last);
		if (got.ratio !== want.ratio)
			report_mismatch("ratio_feature", want.ratio, got.ratio);
	endtask
endclass

module velocity_window_feature_extractor_unit_tb;
	import vwf_pkg::*;

	localparam int DRAIN_CYCLES  = 80;
	localparam int HOLD_CYCLES   = 1500;
	localparam int HOLD_AFTER    = 12;
	localparam int PHASES        = 6;
	localparam int PHASE_SAMPLES = 155;
	localparam int DIRECTED_N    = 24;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [CFG_DATA_W-1:0]   reg_plan [8];
	logic signed [VEL_W-1:0] directed_vals [DIRECTED_N];

	feature_scoreboard sb = new();
	bit                hold_done = 1'b0;
	int                settings_used = 0;

	vwf_vel_if  samples_ch ();
	vwf_feat_if features_ch ();

	velocity_window_feature_extractor_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_ch),
		.features  (features_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop
	initial begin
		#(8 * 2000000);
		$display("velocity_window_feature_extractor_unit: mismatch");
		$finish;
	end

	function automatic int rand_between(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// Offer one sample after an optional gap and hold it until taken
	task send_sample(input logic signed [VEL_W-1:0] v, input int gap);
		if (gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_ch.valid       <= 1'b1;
		samples_ch.velocity_in <= v;
		do
			@(posedge clk);
		while (!samples_ch.ready);
		sb.note_sample(v);
	endtask

	// Wait for every expected item, then let any work without a result finish
	task settle();
		samples_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_features.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_settings();
		int i;
		for (i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data  <= reg_plan[i];
			@(posedge clk);
			sb.set_reg(i[CFG_IDX_W-1:0], reg_plan[i]);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Check every item that leaves the unit
	always @(posedge clk) begin
		if (arst_n && features_ch.valid && features_ch.ready)
			sb.check_features({features_ch.mean_feature, features_ch.std_feature,
				features_ch.last_feature, features_ch.ratio_feature});
	end

	// Output stalls, with one long hold to back the unit up
	initial begin
		int pick;
		features_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			pick = $urandom_range(0, 99);
			if (!hold_done && sb.results >= HOLD_AFTER) begin
				features_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (pick < 55) begin
				features_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end else if (pick < 92) begin
				features_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				features_ch.ready <= 1'b0;
				repeat ($urandom_range(20, 120)) @(posedge clk);
			end
		end
	end

	// Stimulus
	initial begin
		int                      phase;
		int                      n;
		int                      seg_left;
		int                      flat_val;
		int                      gap;
		int                      pick;
		bit                      burst;
		seg_kind_t               kind;
		logic signed [VEL_W-1:0] v;

		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= '0;
		cfg_data               <= '0;
		samples_ch.valid       <= 1'b0;
		samples_ch.velocity_in <= '0;
		directed_vals = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sd10239, 16'sd10240,
			16'sd10241, 16'sh7fff, 16'sd0, 16'sd0, 16'sh5555, 16'shaaaa, 16'sd256,
			16'sd0, 16'sd10240, 16'sd100, -16'sd256, 16'sd2, 16'sd0, 16'sh3fff,
			16'sd5120, 16'sd10242, 16'sd255, 16'sd0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Clip edges, zeros and the full input range under reset settings
		for (n = 0; n < DIRECTED_N; n++)
			send_sample(directed_vals[n], $urandom_range(0, 2));

		for (phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				settle();
				case (phase)
					1: begin
						reg_plan[CFG_MEAN_GAIN]    = 24'h7fffff;
						reg_plan[CFG_STD_GAIN]     = 24'h800000;
						reg_plan[CFG_LAST_GAIN]    = 24'h000000;
						reg_plan[CFG_RATIO_GAIN]   = 24'h7fffff;
						reg_plan[CFG_MEAN_OFFSET]  = 24'h008000;
						reg_plan[CFG_STD_OFFSET]   = 24'h007fff;
						reg_plan[CFG_LAST_OFFSET]  = 24'h000000;
						reg_plan[CFG_RATIO_OFFSET] = 24'hff8000;
					end
					3: begin
						reg_plan[CFG_MEAN_GAIN]    = 24'h800000;
						reg_plan[CFG_STD_GAIN]     = 24'h7fffff;
						reg_plan[CFG_LAST_GAIN]    = 24'h800000;
						reg_plan[CFG_RATIO_GAIN]   = 24'h800000;
						reg_plan[CFG_MEAN_OFFSET]  = 24'h007fff;
						reg_plan[CFG_STD_OFFSET]   = 24'h008000;
						reg_plan[CFG_LAST_OFFSET]  = 24'h3c8000;
						reg_plan[CFG_RATIO_OFFSET] = 24'hc37fff;
					end
					4: begin
						for (n = 0; n < 8; n++)
							reg_plan[n] = CFG_DATA_W'($urandom);
					end
					default: begin
						// Gains that keep most features inside the int8 range
						reg_plan[CFG_MEAN_GAIN]    = CFG_DATA_W'(rand_between(-400000, 400000));
						reg_plan[CFG_STD_GAIN]     = CFG_DATA_W'(rand_between(-800000, 800000));
						reg_plan[CFG_LAST_GAIN]    = CFG_DATA_W'(rand_between(-400000, 400000));
						reg_plan[CFG_RATIO_GAIN]   =
							CFG_DATA_W'(rand_between(-8388608, 8388607));
						reg_plan[CFG_MEAN_OFFSET]  = CFG_DATA_W'(rand_between(-96, 96));
						reg_plan[CFG_STD_OFFSET]   = CFG_DATA_W'(rand_between(-96, 96));
						reg_plan[CFG_LAST_OFFSET]  = CFG_DATA_W'(rand_between(-96, 96));
						reg_plan[CFG_RATIO_OFFSET] = CFG_DATA_W'(rand_between(-96, 96));
					end
				endcase
				write_settings();
			end

			// Segments of one character each: random, in-range, zero, flat, edge and low runs
			seg_left = 0;
			for (n = 0; n < PHASE_SAMPLES; n++) begin
				if (seg_left == 0) begin
					seg_left = rand_between(8, 48);
					kind     = seg_kind_t'($urandom_range(0, 5));
					burst    = ($urandom_range(0, 3) == 0);
					flat_val = rand_between(0, 10240);
				end
				seg_left--;
				case (kind)
					SEG_ANY:   v = VEL_W'($urandom);
					SEG_RANGE: v = VEL_W'(rand_between(0, 10240));
					SEG_ZEROS: v = ($urandom_range(0, 9) < 7) ? 16'sd0
						: VEL_W'(rand_between(0, 10240));
					SEG_FLAT:  v = VEL_W'(flat_val);
					SEG_EDGES: v = $urandom_range(0, 1) ? VEL_W'(rand_between(-2, 2))
						: VEL_W'(rand_between(10238, 10242));
					default:   v = VEL_W'(rand_between(0, 20));
				endcase
				pick = $urandom_range(0, 99);
				if (burst || pick < 70)
					gap = 0;
				else if (pick < 95)
					gap = $urandom_range(1, 4);
				else
					gap = $urandom_range(20, 80);
				send_sample(v, gap);
			end
		end
		settle();

		$display("covered %0d samples (%0d clipped low, %0d clipped high), %0d feature items",
			sb.samples, sb.clipped_low, sb.clipped_high, sb.results);
		$display("across %0d register settings after reset, with one %0d-cycle output hold",
			settings_used, HOLD_CYCLES);
		if (sb.mismatches == 0 && sb.expected_features.size() == 0)
			$display("velocity_window_feature_extractor_unit: match");
		else
			$display("velocity_window_feature_extractor_unit: mismatch");
		$finish;
	end
endmodule

`default_nettype wire

// ----- files.f -----
+incdir+src
src/vwf_pkg.sv
src/vwf_if.sv
src/vwf_serial_mul.sv
src/vwf_isqrt.sv
src/velocity_window_feature_extractor_unit.sv
tb/velocity_window_feature_extractor_unit_tb.sv
